FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rpd_pkg.sv
// Shared widths, codes and types of the permutation dealer.
package rpd_pkg;

  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned WORD_W    = 31;
  localparam int unsigned PICK_W    = 8;
  localparam int unsigned EPOCH_W   = 8;
  localparam int unsigned STEP_W    = $clog2(WORD_W);

  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DRAW  = 1'b1
  } rpd_cmd_e;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_EMPTY = 1'b1
  } rpd_status_e;

  // One slot entry: deal tag (zero = never written) and the stored position.
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [PICK_W-1:0]  data;
  } rpd_entry_t;

  // Request to the remainder unit.
  typedef struct packed {
    logic               start;
    logic [WORD_W-1:0]  dividend;
    logic [COUNT_W-1:0] divisor;
  } rpd_div_req_t;

endpackage

FILE: hw/rtl/rpd_divider.sv
// Bit-serial restoring remainder unit: dividend modulo divisor, one bit per cycle.
module rpd_divider
  import rpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rpd_div_req_t       req_i,
  output logic               done_o,
  output logic [COUNT_W-1:0] rem_o
);

  localparam logic [STEP_W-1:0] LastStep = STEP_W'(WORD_W - 1);

  logic               busy_q;
  logic               done_q;
  logic [STEP_W-1:0]  step_q;
  logic [COUNT_W-1:0] rem_q;
  logic [WORD_W-1:0]  dvd_q;
  logic [COUNT_W-1:0] dsr_q;

  logic [COUNT_W:0]   trial;
  logic [COUNT_W-1:0] rem_d;

  // Shift in the next dividend bit; subtract when it fits.
  always_comb begin
    trial = {rem_q, dvd_q[WORD_W-1]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = COUNT_W'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = trial[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
        rem_q  <= '0;
        dvd_q  <= req_i.dividend;
        dsr_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q  <= rem_d;
        dvd_q  <= {dvd_q[WORD_W-2:0], 1'b0};
        step_q <= step_q + STEP_W'(1);
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: hw/rtl/rpd_slot_mem.sv
// Slot memory: one write port, one read port with registered read data.
module rpd_slot_mem
  import rpd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  rpd_entry_t    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output rpd_entry_t    rd_data_o
);

  rpd_entry_t mem_q [DEPTH];
  rpd_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/random_permutation_dealer_unit.sv
// Top level of the random permutation dealer (draw-and-replace-with-last shuffle).
//
// A start transaction (tuser = 0) sets the number of positions to deal,
// saturated to DEPTH (at most 511), and forgets every slot written in the previous deal;
// its result carries picked 0 and status ok. Each draw transaction (tuser = 1)
// brings a 31-bit random word; the block reduces it modulo the positions still
// remaining, returns the position held in that slot, moves the last remaining
// slot into it and counts down. tlast marks the draw that dealt the final
// position; a draw with nothing left returns status 1 (tuser) and picked 0.
// A draw holds the block from acceptance until its result is made, so no new
// transaction is taken meanwhile: the 31-step bit-serial remainder unit runs,
// then the read-read-write steps on the registered-read slot memory; a start
// goes straight to its result. Slots carry an 8-bit deal tag instead of a
// per-slot valid flop, so a start only bumps the tag. After reset, and after
// every 255th start, the block runs a clearing pass through every slot of the
// slot memory during which s_axis_tready_o stays low. A finished result waits
// in an output register, and the next transaction is accepted while it waits.
`include "assert_macros.svh"

module random_permutation_dealer_unit
  import rpd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input transactions.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [8:0] count, [39:9] random_word
  input  logic        s_axis_tuser_i,  // [0] command
  // Result transactions.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] picked
  output logic        m_axis_tlast_o,  // last_of_run
  output logic        m_axis_tuser_o   // [0] status
);

  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned CountMax = (1 << COUNT_W) - 1;
  localparam int unsigned Cap      = (DEPTH < CountMax) ? DEPTH : CountMax;
  localparam logic [COUNT_W-1:0] CapC    = COUNT_W'(Cap);
  localparam logic [AW-1:0]      LastIdx = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD_K,
    ST_RD_LAST,
    ST_WB,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [COUNT_W-1:0] remaining_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic               clear_pend_q;
  logic [AW-1:0]      clr_cnt_q;
  logic [COUNT_W-1:0] k_q;
  logic [PICK_W-1:0]  pos_q;
  logic [PICK_W-1:0]  res_picked_q;
  logic               res_last_q;
  rpd_status_e        res_status_q;
  logic               m_valid_q;
  logic [PICK_W-1:0]  m_picked_q;
  logic               m_last_q;
  rpd_status_e        m_status_q;

  rpd_cmd_e           in_cmd;
  logic [COUNT_W-1:0] in_count;
  logic [WORD_W-1:0]  in_word;
  logic [COUNT_W-1:0] sat_count;
  logic [COUNT_W-1:0] last_idx;
  logic               s_accept;
  logic               out_free;
  rpd_div_req_t       div_req;
  logic               div_done;
  logic [COUNT_W-1:0] div_rem;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  rpd_entry_t         mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  rpd_entry_t         mem_rdata;
  logic               rd_hit;

  assign in_cmd   = rpd_cmd_e'(s_axis_tuser_i);
  assign in_count = s_axis_tdata_i[COUNT_W-1:0];
  assign in_word  = s_axis_tdata_i[COUNT_W +: WORD_W];

  assign sat_count = (in_count > CapC) ? CapC : in_count;
  assign last_idx  = remaining_q - COUNT_W'(1);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // Kick the remainder unit as a draw with something left is accepted.
  assign div_req.start    = s_accept && (in_cmd == CMD_DRAW) && (remaining_q != '0);
  assign div_req.dividend = in_word;
  assign div_req.divisor  = remaining_q;

  rpd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  // Read slot k, then the last slot; write the last slot's value into k.
  // The clearing pass writes tag zero everywhere.
  assign mem_re    = (state_q == ST_RD_K) || (state_q == ST_RD_LAST);
  assign mem_raddr = (state_q == ST_RD_K) ? AW'(k_q) : AW'(last_idx);
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WB);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : AW'(k_q);

  // A slot counts as written only when its tag matches the current deal.
  assign rd_hit = (mem_rdata.tag == epoch_q);

  always_comb begin
    mem_wdata = '0;
    if (state_q == ST_WB) begin
      mem_wdata.tag  = epoch_q;
      mem_wdata.data = rd_hit ? mem_rdata.data : last_idx[PICK_W-1:0];
    end
  end

  rpd_slot_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      remaining_q  <= '0;
      epoch_q      <= EPOCH_FIRST;
      clear_pend_q <= 1'b0;
      clr_cnt_q    <= '0;
      k_q          <= '0;
      pos_q        <= '0;
      res_picked_q <= '0;
      res_last_q   <= 1'b0;
      res_status_q <= STATUS_OK;
      m_valid_q    <= 1'b0;
      m_picked_q   <= '0;
      m_last_q     <= 1'b0;
      m_status_q   <= STATUS_OK;
    end else begin
      // Output register: load a finished result, drop it once taken.
      if ((state_q == ST_DONE) && out_free) begin
        m_valid_q  <= 1'b1;
        m_picked_q <= res_picked_q;
        m_last_q   <= res_last_q;
        m_status_q <= res_status_q;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          if (clr_cnt_q == LastIdx) begin
            clr_cnt_q <= '0;
            state_q   <= ST_IDLE;
          end else begin
            clr_cnt_q <= clr_cnt_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (s_accept) begin
            res_picked_q <= '0;
            res_last_q   <= 1'b0;
            if (in_cmd == CMD_START) begin
              res_status_q <= STATUS_OK;
              remaining_q  <= sat_count;
              // Advance the deal tag; on wrap, clear all tags afterwards.
              if (epoch_q == EPOCH_LAST) begin
                epoch_q      <= EPOCH_FIRST;
                clear_pend_q <= 1'b1;
              end else begin
                epoch_q <= epoch_q + EPOCH_W'(1);
              end
              state_q <= ST_DONE;
            end else if (remaining_q == '0) begin
              res_status_q <= STATUS_EMPTY;
              state_q      <= ST_DONE;
            end else begin
              res_status_q <= STATUS_OK;
              state_q      <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            k_q     <= div_rem;
            state_q <= ST_RD_K;
          end
        end
        ST_RD_K: begin
          state_q <= ST_RD_LAST;
        end
        ST_RD_LAST: begin
          pos_q   <= rd_hit ? mem_rdata.data : k_q[PICK_W-1:0];
          state_q <= ST_WB;
        end
        ST_WB: begin
          remaining_q  <= last_idx;
          res_picked_q <= pos_q;
          res_last_q   <= (last_idx == '0);
          res_status_q <= STATUS_OK;
          state_q      <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            clear_pend_q <= 1'b0;
            state_q      <= clear_pend_q ? ST_CLEAR : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_picked_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_status_q;

  `ASSERT_IMPL(a_rem_cap, 1'b1, remaining_q <= CapC, "remaining exceeds capacity")
  `ASSERT_IMPL(a_div_range, (state_q == ST_DIV) && div_done, div_rem < remaining_q,
               "remainder not below remaining count")
  `ASSERT_IMPL(a_wb_range, state_q == ST_WB, k_q < remaining_q, "slot write out of range")
  `ASSERT_NEXT(a_one_item, s_accept, !s_axis_tready_o, "second item taken while busy")

endmodule
